[rtl/core/plst_pkg.sv]
// plst_pkg: shared constants, command/status codes and transaction types
// for the positional list engine. No dependencies.
package plst_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Working width for position/count arithmetic; covers the 8-bit position field.
    localparam int EW       = ((CNT_W > 8) ? CNT_W : 8) + 1;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         count;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture accepted input transaction
        logic scan_init;  // set up scan index and length
        logic scan_rd;    // issue one scan read and advance
        logic rd_single;  // read entry at position-1
        logic put;        // write inserted value at position-1
        logic post;       // load result register, commit count
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       err;       // precheck failed
        logic       scan_end;  // no scan reads left
        logic       rd_pend;   // scan read in flight
        logic       hit;       // search matched
        logic       out_free;  // result register can take a result
    } t_dp_sts;

endpackage

[rtl/core/plst_ram.sv]
// plst_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module plst_ram #(
    parameter int  W     = 32,
    parameter int  DEPTH = 128,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/plst_ctrl.sv]
// plst_ctrl: command sequencer for the positional list engine.
// Depends on plst_pkg; drives plst_dp through t_dp_ctl / t_dp_sts.
module plst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  plst_pkg::t_dp_sts i_sts,
    output plst_pkg::t_dp_ctl o_ctl
);
    import plst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.err) begin
                    n_state = S_FIN;
                end else begin
                    priority case (i_sts.cmd)
                        CMD_INSERT, CMD_DELETE, CMD_SEARCH: begin
                            o_ctl.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                        CMD_READ: begin
                            o_ctl.rd_single = 1'b1;
                            n_state         = S_FIN;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.cmd == CMD_SEARCH && i_sts.hit) begin
                    n_state = S_FIN;
                end else if (!i_sts.scan_end) begin
                    o_ctl.scan_rd = 1'b1;
                end else if (!i_sts.rd_pend) begin
                    n_state = (i_sts.cmd == CMD_INSERT) ? S_PUT : S_FIN;
                end
            end
            S_PUT: begin
                o_ctl.put = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[rtl/core/plst_dp.sv]
// plst_dp: list datapath - entry RAM, count, scan index, result register.
// Depends on plst_pkg and plst_ram; sequenced by plst_ctrl.
module plst_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plst_pkg::t_in     i_in_data,
    input  plst_pkg::t_dp_ctl i_ctl,
    output plst_pkg::t_dp_sts o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output plst_pkg::t_out    o_out_data
);
    import plst_pkg::*;

    // captured transaction
    logic [2:0]         r_cmd;
    logic [7:0]         r_pos;
    logic signed [31:0] r_val;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] r_idx;
    logic [CNT_W-1:0]  r_left;
    logic              r_rd_vld;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_hit;
    logic [CNT_W-1:0]  r_found;
    t_out              r_res;
    logic              r_res_vld;

    logic [EW-1:0]     pos_e;
    logic [EW-1:0]     cnt_e;
    logic [EW-1:0]     found_e;
    logic [1:0]        pre_st;
    logic [1:0]        fin_st;
    logic              hit_now;
    logic              wb;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;
    logic [ADDR_W-1:0] pos_addr;

    assign pos_e    = EW'(r_pos);
    assign cnt_e    = EW'(r_count);
    assign pos_addr = ADDR_W'(pos_e - EW'(1));

    // precheck on captured command against current count
    always_comb begin
        pre_st = ST_OK;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (cnt_e == EW'(CAPACITY)) pre_st = ST_FULL;
                else if (pos_e == '0 || pos_e > cnt_e + EW'(1)) pre_st = ST_BADPOS;
            end
            CMD_DELETE, CMD_READ: begin
                if (cnt_e == '0) pre_st = ST_EMPTY;
                else if (pos_e == '0 || pos_e > cnt_e) pre_st = ST_BADPOS;
            end
            CMD_SEARCH, CMD_CLEAR: begin
                if (cnt_e == '0) pre_st = ST_EMPTY;
            end
            default: pre_st = ST_BADPOS;
        endcase
    end

    assign hit_now = r_rd_vld && (r_cmd == CMD_SEARCH) && !r_hit
                     && (ram_rdata == 32'(r_val));

    // shift write-back: insert moves up one slot, delete down one slot
    assign wb        = r_rd_vld && (r_cmd == CMD_INSERT || r_cmd == CMD_DELETE);
    assign ram_we    = wb || i_ctl.put;
    assign ram_waddr = i_ctl.put ? pos_addr
                     : (r_cmd == CMD_INSERT) ? r_rd_addr + ADDR_W'(1)
                     : r_rd_addr - ADDR_W'(1);
    assign ram_wdata = i_ctl.put ? 32'(r_val) : ram_rdata;
    assign ram_re    = i_ctl.scan_rd || i_ctl.rd_single;
    assign ram_raddr = i_ctl.rd_single ? pos_addr : r_idx;

    plst_ram #(
        .W     (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        fin_st = pre_st;
        if (pre_st == ST_OK && r_cmd == CMD_SEARCH && !r_hit) fin_st = ST_EMPTY;
    end

    always_comb begin
        n_count = r_count;
        if (fin_st == ST_OK) begin
            priority case (r_cmd)
                CMD_INSERT: n_count = r_count + CNT_W'(1);
                CMD_DELETE: n_count = r_count - CNT_W'(1);
                CMD_CLEAR:  n_count = '0;
                default:    n_count = r_count;
            endcase
        end
    end

    assign found_e = EW'(r_found);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_in_data.cmd;
            r_pos <= i_in_data.position;
            r_val <= i_in_data.value;
        end
        if (i_ctl.scan_rd) begin
            r_rd_addr <= r_idx;
        end
        if (hit_now) begin
            r_found <= CNT_W'(EW'(r_rd_addr) + EW'(1));
        end
        if (i_ctl.post) begin
            r_res.status         <= fin_st;
            r_res.read_value     <= (r_cmd == CMD_READ && fin_st == ST_OK)
                                    ? ram_rdata : '0;
            r_res.found_position <= (r_cmd == CMD_SEARCH && fin_st == ST_OK)
                                    ? found_e[7:0] : '0;
            r_res.count          <= 8'(EW'(n_count));
        end
        if (i_ctl.scan_init) begin
            priority case (r_cmd)
                CMD_INSERT: r_idx <= ADDR_W'(cnt_e - EW'(1));
                CMD_DELETE: r_idx <= ADDR_W'(pos_e);
                default:    r_idx <= '0;
            endcase
        end else if (i_ctl.scan_rd) begin
            r_idx <= (r_cmd == CMD_INSERT) ? r_idx - ADDR_W'(1) : r_idx + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_ctl.scan_rd;
            if (i_ctl.load) begin
                r_hit <= 1'b0;
            end else if (hit_now) begin
                r_hit <= 1'b1;
            end
            if (i_ctl.scan_init) begin
                priority case (r_cmd)
                    CMD_INSERT: r_left <= CNT_W'(cnt_e - pos_e + EW'(1));
                    CMD_DELETE: r_left <= CNT_W'(cnt_e - pos_e);
                    default:    r_left <= r_count;
                endcase
            end else if (i_ctl.scan_rd) begin
                r_left <= r_left - CNT_W'(1);
            end
            if (i_ctl.post) begin
                r_count   <= n_count;
                r_res_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.err      = (pre_st != ST_OK);
    assign o_sts.scan_end = (r_left == '0);
    assign o_sts.rd_pend  = r_rd_vld;
    assign o_sts.hit      = r_hit || hit_now;
    assign o_sts.out_free = !r_res_vld || i_out_ready;

    assign o_out_valid = r_res_vld;
    assign o_out_data  = r_res;

    // shift write-back never lands on the slot being read in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("plst_dp: RAM read/write address clash");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_count) <= EW'(CAPACITY))
        else $error("plst_dp: count above capacity");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.post && r_cmd == CMD_INSERT && fin_st == ST_OK)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("plst_dp: insert did not grow count");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.post && fin_st == ST_FULL) |-> (EW'(r_count) == EW'(CAPACITY)))
        else $error("plst_dp: full status on non-full list");

    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.post |-> (!r_rd_vld || r_cmd == CMD_SEARCH))
        else $error("plst_dp: result posted with shift still in flight");

endmodule

[rtl/core/positional_list_engine_unit.sv]
// positional_list_engine_unit: top level of the positional list engine.
// Depends on plst_pkg, plst_ctrl, plst_dp (which holds plst_ram).
//
// Bounded ordered list of up to CAPACITY (128) signed 32-bit entries, positions
// counted from 1. One command transaction in gives exactly one result
// transaction out. Commands: insert (shift later entries up), delete (shift
// later entries down), read, search (first matching position, 0 if none) and
// clear. Errors (bad position, full, empty/not found) leave the list unchanged;
// every result carries the count after the command. Entries live in a single
// one-read/one-write RAM and all shifting and searching goes through that one
// read port at one entry per cycle. One command is processed at a time; the
// next command is accepted as soon as the previous result is in the output
// register, even if the consumer has not taken it yet. No clearing pass is
// needed after reset: entries past the count are never read.
module positional_list_engine_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // command channel
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  plst_pkg::t_in  i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output plst_pkg::t_out o_out_data
);
    import plst_pkg::*;

    t_dp_ctl ctl;   // sequencer commands to datapath
    t_dp_sts sts;   // datapath status back to sequencer

    // sequencer: one command transaction at a time
    plst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    // datapath: entry RAM, count, scan pointer, result register
    plst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[verif/plst_result_checker.sv]
`timescale 1ns / 100ps
// plst_result_checker: keeps a shadow copy of the positional list, predicts each
// result transaction from the accepted commands and compares field by field.
// Depends on plst_pkg only.
module plst_result_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  plst_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  plst_pkg::t_out i_out_data,
    output int             o_mismatch_cnt,
    output int             o_pending,
    output int             o_list_len
);
    import plst_pkg::*;

    localparam int PRINT_MAX = 40;

    logic signed [31:0] shadow_list [CAPACITY];
    int                 shadow_len   = 0;
    int                 mismatch_cnt = 0;
    t_out               expected_results [$];

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_MAX) begin
            $display("%0t ns: list result mismatch: %s", $time, what);
        end
    endtask

    // Apply one command to the shadow list; errors leave it untouched.
    task automatic apply_list_cmd(input t_in c, output t_out r);
        int pos;
        int k;
        pos      = int'(c.position);
        r        = '0;
        r.status = ST_OK;
        case (c.cmd)
            CMD_INSERT: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos < 1 || pos > shadow_len + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = shadow_len; k >= pos; k--) begin
                        shadow_list[k] = shadow_list[k - 1];
                    end
                    shadow_list[pos - 1] = c.value;
                    shadow_len++;
                end
            end
            CMD_DELETE: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos < 1 || pos > shadow_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (k = pos; k < shadow_len; k++) begin
                        shadow_list[k - 1] = shadow_list[k];
                    end
                    shadow_len--;
                end
            end
            CMD_READ: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos < 1 || pos > shadow_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.read_value = shadow_list[pos - 1];
                end
            end
            CMD_SEARCH: begin
                r.status = ST_EMPTY;
                for (k = 0; k < shadow_len; k++) begin
                    if (shadow_list[k] == c.value) begin
                        r.found_position = 8'(k + 1);
                        r.status         = ST_OK;
                        break;
                    end
                end
            end
            CMD_CLEAR: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_len = 0;
                end
            end
            default: begin
                r.status = ST_BADPOS;
            end
        endcase
        r.count = 8'(shadow_len);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out  exp_res;
        string diffs;
        if (!i_rst_n) begin
            expected_results.delete();
            shadow_len = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_list_cmd(i_in_data, exp_res);
                expected_results.push_back(exp_res);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result st=%0d rd=%0h fp=%0d cnt=%0d",
                        i_out_data.status, i_out_data.read_value,
                        i_out_data.found_position, i_out_data.count));
                end else begin
                    exp_res = expected_results.pop_front();
                    diffs   = "";
                    if (i_out_data.status !== exp_res.status) begin
                        diffs = {diffs, $sformatf(" status got %0d exp %0d",
                            i_out_data.status, exp_res.status)};
                    end
                    if (i_out_data.read_value !== exp_res.read_value) begin
                        diffs = {diffs, $sformatf(" read_value got %0h exp %0h",
                            i_out_data.read_value, exp_res.read_value)};
                    end
                    if (i_out_data.found_position !== exp_res.found_position) begin
                        diffs = {diffs, $sformatf(" found_position got %0d exp %0d",
                            i_out_data.found_position, exp_res.found_position)};
                    end
                    if (i_out_data.count !== exp_res.count) begin
                        diffs = {diffs, $sformatf(" count got %0d exp %0d",
                            i_out_data.count, exp_res.count)};
                    end
                    if (diffs != "") begin
                        report_mismatch({"result", diffs});
                    end
                end
            end
        end
        o_pending      <= expected_results.size();
        o_list_len     <= shadow_len;
        o_mismatch_cnt <= mismatch_cnt;
    end

endmodule

[verif/tb_positional_list_engine_unit.sv]
`timescale 1ns / 100ps
// tb_positional_list_engine_unit: command stimulus, result-side pacing and the
// final verdict for the positional list engine.
// Depends on plst_pkg, positional_list_engine_unit and plst_result_checker.
module tb_positional_list_engine_unit;
    import plst_pkg::*;

    localparam int          RAND_ITEMS     = 700;
    localparam int          IDLE_PCT       = 26;   // idle chance per cycle, both sides
    localparam int          HOLD_AT        = 90;   // transactions sent before the long stall
    localparam int          HOLD_CYCLES    = 400;
    localparam int          CALM_FIRST     = 300;  // random transactions with no idling
    localparam int          CALM_LAST      = 420;
    localparam int          PAUSE_AT       = 460;  // sender drains the block here
    localparam int          FULL_EXTRA     = 12;   // commands issued against a full list
    localparam int          DRAIN_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam logic [2:0]  CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0]  CMD_RSVD_LAST  = 3'd7;

    // Random traffic comes in phases, each with its own command mix.
    typedef enum logic [1:0] {MODE_FILL, MODE_GROW, MODE_SHRINK, MODE_MIX} t_mode;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    t_in  cmd_data  = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    t_out res_data;

    int   mismatch_cnt;
    int   pending_cnt;
    int   list_len;        // predicted list length, lags by at most one command
    int   n_sent = 0;
    logic calm   = 1'b0;   // no idling on either side while set

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    positional_list_engine_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (cmd_ready),
        .i_in_data   (cmd_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data)
    );

    plst_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (cmd_valid),
        .i_in_ready     (cmd_ready),
        .i_in_data      (cmd_data),
        .i_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .i_out_data     (res_data),
        .o_mismatch_cnt (mismatch_cnt),
        .o_pending      (pending_cnt),
        .o_list_len     (list_len)
    );

    function automatic t_in list_cmd(input logic [2:0] c, input logic [7:0] p,
                                     input logic signed [31:0] v);
        t_in item;
        item.cmd      = c;
        item.position = p;
        item.value    = v;
        return item;
    endfunction

    // Half the values come from a tiny pool so that searches hit and duplicates
    // exercise the first-match rule; the rest are extremes or full random words.
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return 32'(int'($urandom_range(0, 6)) - 3);
        end
        if (r < 6) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly legal positions with the ends favored; some zero, some past the
    // end, some fully random 8-bit codes.
    function automatic logic [7:0] pick_position(input logic [2:0] c, input int len);
        int lim;
        int r;
        lim = (c == CMD_INSERT) ? len + 1 : len;
        if (lim > 255) begin
            lim = 255;
        end
        r = $urandom_range(0, 99);
        if (lim < 1 || r < 10) begin
            return 8'($urandom_range(0, 255));
        end
        if (r < 16) begin
            return 8'd0;
        end
        if (r < 22) begin
            return (lim >= 255) ? 8'd0 : 8'($urandom_range(lim + 1, 255));
        end
        if (r < 34) begin
            return 8'd1;
        end
        if (r < 46) begin
            return 8'(lim);
        end
        return 8'($urandom_range(1, lim));
    endfunction

    // Thresholds are cumulative percentages: insert, delete, read, search; the
    // remainder is reserved codes, plus a rare clear outside the fill phase.
    function automatic t_in next_list_cmd(input t_mode mode, input int len);
        int         r;
        int         p_ins;
        int         p_del;
        int         p_rd;
        int         p_srch;
        logic [2:0] c;
        case (mode)
            MODE_FILL: begin
                p_ins = 80; p_del = 84; p_rd = 92; p_srch = 98;
            end
            MODE_GROW: begin
                p_ins = 55; p_del = 68; p_rd = 82; p_srch = 96;
            end
            MODE_SHRINK: begin
                p_ins = 15; p_del = 70; p_rd = 82; p_srch = 95;
            end
            default: begin
                p_ins = 30; p_del = 55; p_rd = 75; p_srch = 94;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < p_ins) begin
            c = CMD_INSERT;
        end else if (r < p_del) begin
            c = CMD_DELETE;
        end else if (r < p_rd) begin
            c = CMD_READ;
        end else if (r < p_srch) begin
            c = CMD_SEARCH;
        end else if (r == 99 && mode != MODE_FILL) begin
            c = CMD_CLEAR;
        end else begin
            c = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        end
        return list_cmd(c, pick_position(c, len), pick_value());
    endfunction

    // Offer one command transaction and hold it until accepted. Called at a
    // rising edge; valid is only dropped when an idle gap is inserted, so a
    // back-to-back transaction never lowers and raises valid in one step.
    task automatic send_cmd(input t_in item);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                cmd_valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        @(posedge clk);
        while (!cmd_ready) begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    // Stop offering and wait until every predicted result has been taken.
    // The first edge lets the checker's pending count catch up.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0) begin
            @(posedge clk);
        end
    endtask

    // Result side: random back-pressure, none during the calm window, and one
    // long hold-off early on so the engine fills up and stalls its input.
    initial begin : result_pacing
        int unsigned held;
        bit          hold_done;
        hold_done = 1'b0;
        @(posedge clk);
        forever begin
            if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                res_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(posedge clk);
                end
            end
            res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge clk);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
            @(posedge clk);
        end
        $display("[positional_list_engine_unit] ERROR");
        $finish;
    end

    initial begin : stimulus
        int         i;
        int         at_full;
        int         phase_left;
        logic [2:0] rc;
        t_mode      mode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command on an empty list first.
        send_cmd(list_cmd(CMD_READ,   8'd1, 32'sd0));
        send_cmd(list_cmd(CMD_DELETE, 8'd1, 32'sd0));
        send_cmd(list_cmd(CMD_SEARCH, 8'd0, 32'sd0));
        send_cmd(list_cmd(CMD_CLEAR,  8'd0, 32'sd0));
        // Insert at position zero and one past the append slot.
        send_cmd(list_cmd(CMD_INSERT, 8'd0, 32'sd5));
        send_cmd(list_cmd(CMD_INSERT, 8'd2, 32'sd5));
        // Build [min, 0, max, 0, -1] through front, middle and tail inserts.
        send_cmd(list_cmd(CMD_INSERT, 8'd1, 32'sh7FFF_FFFF));
        send_cmd(list_cmd(CMD_INSERT, 8'd1, 32'sh8000_0000));
        send_cmd(list_cmd(CMD_INSERT, 8'd3, 32'shFFFF_FFFF));
        send_cmd(list_cmd(CMD_INSERT, 8'd2, 32'sd0));
        send_cmd(list_cmd(CMD_INSERT, 8'd4, 32'sd0));
        // Reads at zero, far out of range and at the last entry.
        send_cmd(list_cmd(CMD_READ,   8'd0,   32'sd0));
        send_cmd(list_cmd(CMD_READ,   8'd255, 32'sd0));
        send_cmd(list_cmd(CMD_READ,   8'd5,   32'sd0));
        // Searches: unique hit, duplicate (first match wins), miss.
        send_cmd(list_cmd(CMD_SEARCH, 8'd0, 32'sh7FFF_FFFF));
        send_cmd(list_cmd(CMD_SEARCH, 8'd0, 32'sd0));
        send_cmd(list_cmd(CMD_SEARCH, 8'd0, 32'sd5));
        // Delete past the end, then the head and the tail.
        send_cmd(list_cmd(CMD_DELETE, 8'd6, 32'sd0));
        send_cmd(list_cmd(CMD_DELETE, 8'd1, 32'sd0));
        send_cmd(list_cmd(CMD_DELETE, 8'd4, 32'sd0));
        // Reserved command codes are rejected as bad position.
        for (rc = CMD_RSVD_FIRST; rc != 3'd0; rc++) begin
            send_cmd(list_cmd(rc, 8'hFF, 32'shFFFF_FFFF));
        end
        // Clear a non-empty list, then read from the empty one.
        send_cmd(list_cmd(CMD_CLEAR, 8'd0, 32'sd0));
        send_cmd(list_cmd(CMD_READ,  8'd1, 32'sd0));
        wait_drained();

        // Random: fill the list to capacity first (full-list rejects), then
        // alternate grow / shrink / mixed phases of random length.
        mode       = MODE_FILL;
        at_full    = 0;
        phase_left = 0;
        for (i = 0; i < RAND_ITEMS; i++) begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            if (mode == MODE_FILL) begin
                if (list_len >= CAPACITY) begin
                    at_full++;
                end
                if (at_full >= FULL_EXTRA || i >= RAND_ITEMS / 2) begin
                    mode       = MODE_SHRINK;
                    phase_left = $urandom_range(80, 160);
                end
            end else if (phase_left <= 0) begin
                mode       = t_mode'($urandom_range(int'(MODE_GROW), int'(MODE_MIX)));
                phase_left = $urandom_range(30, 120);
            end
            // Sender pause: let every outstanding result come back.
            if (i == PAUSE_AT) begin
                wait_drained();
            end
            send_cmd(next_list_cmd(mode, list_len));
            phase_left--;
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("[positional_list_engine_unit] OK");
        end else begin
            $display("[positional_list_engine_unit] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/plst_pkg.sv
rtl/core/plst_ram.sv
rtl/core/plst_ctrl.sv
rtl/core/plst_dp.sv
rtl/core/positional_list_engine_unit.sv
verif/plst_result_checker.sv
verif/tb_positional_list_engine_unit.sv
